FILE: rtl/core/svtt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// svtt_pkg
// Types and constants for the sensor voltage to temperature converter:
// register indexes, mode and status codes, and the sensor voltage table.
// ----------------------------------------------------------------------------
package svtt_pkg;

  localparam int VOLT_W    = 12;
  localparam int TEMP_W    = 13;
  localparam int TBL_LEN   = 41;
  localparam int TBL_IDX_W = 6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_MAX  = 2'd1;
  localparam logic [1:0] CFG_MIN  = 2'd2;

  // Conversion modes; the remaining codes are invalid.
  localparam logic [1:0] MODE_TABLE = 2'd0;
  localparam logic [1:0] MODE_SQRT  = 2'd1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVER     = 2'd1,
    ST_UNDER    = 2'd2,
    ST_BAD_MODE = 2'd3
  } status_t;

  // Sensor output in mV for -50 C up to 150 C in 5 degree steps.
  localparam logic [VOLT_W-1:0] VOLT_TBL [TBL_LEN] = '{
    12'd1299, 12'd1273, 12'd1247, 12'd1221, 12'd1194, 12'd1168, 12'd1141,
    12'd1114, 12'd1088, 12'd1061, 12'd1034, 12'd1007, 12'd980,  12'd952,
    12'd925,  12'd898,  12'd871,  12'd843,  12'd816,  12'd788,  12'd760,
    12'd732,  12'd704,  12'd676,  12'd647,  12'd619,  12'd591,  12'd562,
    12'd534,  12'd505,  12'd476,  12'd448,  12'd419,  12'd390,  12'd361,
    12'd332,  12'd302,  12'd273,  12'd243,  12'd213,  12'd183
  };

  function automatic logic [VOLT_W-1:0] volt_entry(input logic [TBL_IDX_W-1:0] i);
    logic [VOLT_W-1:0] e;
    e = '0;
    if (i < TBL_IDX_W'(TBL_LEN)) begin
      e = VOLT_TBL[i];
    end
    return e;
  endfunction

  // Square-root mode: R = R_BASE - R_SLOPE * v in units of 1e-6.
  localparam logic [25:0] R_BASE  = 26'd36445060;
  localparam logic [12:0] R_SLOPE = 13'd7040;

  // T16 = floor((50*S + SQ_BIAS) / SQ_DIV) - SQ_OFFSET
  localparam logic [12:0] SQ_DIV    = 13'd2816;
  localparam logic [26:0] SQ_BIAS   = 27'd640;
  localparam logic [15:0] SQ_OFFSET = 16'd24547;

  // Temperature for the first table entry, -50 C in 1/16 degree.
  localparam logic [TEMP_W-1:0] TEMP_COLD = 13'h1CE0;

endpackage
`default_nettype wire

FILE: rtl/core/sensor_voltage_to_temperature.sv
`timescale 1ns / 1ps
`default_nettype none
// Table mode walks at most min(TABLE_ENTRIES, 41) entries, then divides and sums, or
// finishes when the first entry matches or none does; square-root mode takes the root,
// scales, divides and sums; out of range or bad mode finishes at once. One word is in
// flight at a time, the next is taken in the cycle after the result is registered, and a
// result not yet taken holds the converter. The table walk is serial and the divider is
// shared. Reset (rst, synchronous) empties it and loads mode 0, 1299/183 mV.
// ----------------------------------------------------------------------------
// sensor_voltage_to_temperature
// Converts a sensor voltage in mV to temperature in 1/16 degree C, by table
// interpolation or by the quadratic formula, using a serial square root and
// a shared restoring divider.
// ----------------------------------------------------------------------------
module sensor_voltage_to_temperature #(
  parameter int TABLE_ENTRIES = 41
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [svtt_pkg::VOLT_W-1:0] cfg_data,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [11:0] voltage_mv
  // Output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [12:0] temperature_q4
  output logic [1:0]       m_axis_tuser    // [1:0] status
);
  import svtt_pkg::*;

  localparam int LIMIT = (TABLE_ENTRIES < TBL_LEN) ? TABLE_ENTRIES : TBL_LEN;
  localparam int IDX_W = (LIMIT > 1) ? $clog2(LIMIT) : 1;
  localparam logic [3:0] K_TABLE = 4'd6;
  localparam logic [3:0] K_SQRT  = 4'd14;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SEARCH = 7'b0000010,
    S_SQRT   = 7'b0000100,
    S_SCALE  = 7'b0001000,
    S_DIVIDE = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t               state;
  logic [1:0]           mode;
  logic [VOLT_W-1:0]    max_mv;
  logic [VOLT_W-1:0]    min_mv;

  logic [VOLT_W-1:0]    volt;
  logic [VOLT_W-1:0]    prev_mv;
  logic [IDX_W-1:0]     idx;

  logic [41:0]          rad;
  logic [20:0]          root;
  logic [22:0]          srem;
  logic [4:0]           sq_cnt;

  logic [26:0]          rem;
  logic [12:0]          dvs;
  logic [3:0]           k;
  logic [14:0]          quo;
  logic signed [15:0]   offset;

  logic [TEMP_W-1:0]    res_temp;
  status_t              res_st;
  logic                 out_valid;
  logic [TEMP_W-1:0]    out_temp;
  status_t              out_st;

  logic [VOLT_W-1:0]    in_volt;
  logic [VOLT_W-1:0]    entry;
  logic [VOLT_W-1:0]    diff;
  logic [VOLT_W-1:0]    den;
  logic [19:0]          num;
  logic [25:0]          r_val;
  logic [24:0]          sq_rem_n;
  logic [24:0]          sq_trial;
  logic [26:0]          div_sh;
  logic                 div_ge;
  logic signed [16:0]   sum;
  logic [TEMP_W-1:0]    sat_temp;
  logic [26:0]          scaled;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_temp};
  assign m_axis_tuser  = out_st;

  always_comb begin
    in_volt  = s_axis_tdata[VOLT_W-1:0];
    entry    = volt_entry(TBL_IDX_W'(idx));
    diff     = prev_mv - volt;
    den      = prev_mv - entry;
    // 160 * (hi - v) + (hi - lo): numerator of the rounded interpolation step.
    num      = {1'b0, diff, 7'b0} + {3'b000, diff, 5'b0} + {8'b0, den};
    r_val    = R_BASE - 26'(R_SLOPE * in_volt);
    sq_rem_n = {srem, rad[41:40]};
    sq_trial = {2'b00, root, 2'b01};
    div_sh   = 27'(dvs) << k;
    div_ge   = (rem >= div_sh);
    sum      = {offset[15], offset} + $signed({2'b00, quo});
    if (sum < -17'sd4096) begin
      sat_temp = 13'h1000;
    end else if (sum > 17'sd4095) begin
      sat_temp = 13'h0FFF;
    end else begin
      sat_temp = sum[TEMP_W-1:0];
    end
    scaled   = 27'(root * 6'd50) + SQ_BIAS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mode      <= MODE_TABLE;
      max_mv    <= 12'd1299;
      min_mv    <= 12'd183;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MODE: mode   <= cfg_data[1:0];
          CFG_MAX:  max_mv <= cfg_data;
          CFG_MIN:  min_mv <= cfg_data;
          default:  ;
        endcase
      end

      // The finish step reloads the output register itself.
      if (out_valid && m_axis_tready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            volt     <= in_volt;
            res_temp <= '0;
            if (mode == MODE_TABLE) begin
              if (in_volt > max_mv) begin
                res_st <= ST_OVER;
                state  <= S_FINISH;
              end else if (in_volt < min_mv) begin
                res_st <= ST_UNDER;
                state  <= S_FINISH;
              end else begin
                res_st <= ST_OK;
                idx    <= '0;
                state  <= S_SEARCH;
              end
            end else if (mode == MODE_SQRT) begin
              res_st <= ST_OK;
              rad    <= {r_val, 16'b0};
              root   <= '0;
              srem   <= '0;
              sq_cnt <= 5'd20;
              state  <= S_SQRT;
            end else begin
              res_st <= ST_BAD_MODE;
              state  <= S_FINISH;
            end
          end
        end

        // One table entry per cycle until the first entry at or below the voltage, or the last one.
        S_SEARCH: begin
          if (entry <= volt) begin
            if (idx == '0) begin
              res_temp <= TEMP_COLD;
              state    <= S_FINISH;
            end else begin
              rem    <= {7'b0, num};
              dvs    <= {den, 1'b0};
              k      <= K_TABLE;
              quo    <= '0;
              offset <= $signed(16'(TBL_IDX_W'(idx)) * 16'd80 - 16'd880);
              state  <= S_DIVIDE;
            end
          end else if (idx == IDX_W'(LIMIT - 1)) begin
            res_temp <= TEMP_COLD;
            state    <= S_FINISH;
          end else begin
            prev_mv <= entry;
            idx     <= idx + 1'b1;
          end
        end

        // Square root, two radicand bits per cycle.
        S_SQRT: begin
          rad <= {rad[39:0], 2'b00};
          if (sq_rem_n >= sq_trial) begin
            srem <= 23'(sq_rem_n - sq_trial);
            root <= {root[19:0], 1'b1};
          end else begin
            srem <= sq_rem_n[22:0];
            root <= {root[19:0], 1'b0};
          end
          if (sq_cnt == '0) begin
            state <= S_SCALE;
          end else begin
            sq_cnt <= sq_cnt - 1'b1;
          end
        end

        S_SCALE: begin
          rem    <= scaled;
          dvs    <= SQ_DIV;
          k      <= K_SQRT;
          quo    <= '0;
          offset <= -$signed(SQ_OFFSET);
          state  <= S_DIVIDE;
        end

        // Restoring division, one quotient bit per cycle.
        S_DIVIDE: begin
          if (div_ge) begin
            rem <= rem - div_sh;
          end
          quo <= {quo[13:0], div_ge};
          if (k == '0) begin
            state <= S_SUM;
          end else begin
            k <= k - 1'b1;
          end
        end

        S_SUM: begin
          res_temp <= sat_temp;
          state    <= S_FINISH;
        end

        S_FINISH: begin
          if (!out_valid || m_axis_tready) begin
            out_temp  <= res_temp;
            out_st    <= res_st;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |-> (m_axis_tdata == 16'd0))
    else $error("error status with nonzero temperature");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted while busy");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVIDE) |-> (k <= K_SQRT))
    else $error("divider step out of range");

  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SEARCH) |-> (32'(idx) < LIMIT))
    else $error("table walk past last entry");

  a_sqrt_exit: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQRT && sq_cnt == '0) |=> (state == S_SCALE))
    else $error("square root did not hand over to scaling");

endmodule
`default_nettype wire
